// File: rtl/bus_slave_frame_responder_unit_defines.svh
// Assertion macros for the bus slave frame responder RTL.
`ifndef BUS_SLAVE_FRAME_RESPONDER_UNIT_DEFINES_SVH
`define BUS_SLAVE_FRAME_RESPONDER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Condition implies a consequence in the next cycle.
`define BSFR_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
// Condition implies a consequence in the same cycle.
`define BSFR_ASSERT_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`else
`define BSFR_ASSERT_NEXT(lbl, a, b, msg)
`define BSFR_ASSERT_NOW(lbl, a, b, msg)
`endif
`endif

// File: rtl/bsfr_pkg.sv
// Shared constants, types and the CRC function of the bus slave frame responder.
`default_nettype none
package bsfr_pkg;
  localparam int FRAME_BYTES = 64;
  localparam int LEN_W = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_BYTES);

  localparam logic [7:0] FN_WRITE = 8'h10;
  localparam logic [7:0] FN_RW = 8'h17;
  localparam logic [8:0] HDR16 = 9'd7;
  localparam logic [8:0] HDR23 = 9'd11;

  localparam logic [0:0] CFG_OWN_ADDR = 1'b0;
  localparam logic [0:0] CFG_GAP = 1'b1;

  localparam logic [2:0] ST_BYTE = 3'd0;
  localparam logic [2:0] ST_BCAST_OK = 3'd1;
  localparam logic [2:0] ST_BAD_CRC = 3'd2;
  localparam logic [2:0] ST_BAD_FN = 3'd3;
  localparam logic [2:0] ST_UNSUPP = 3'd4;
  localparam logic [2:0] ST_NOT_ADDR = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_go;
    logic decide;
    logic reply_go;
    logic crc_lo;
    logic crc_hi;
  } bsfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_end;
    logic scan_done;
    logic is_reply;
    logic reply_last;
  } bsfr_sts_t;

  // CRC-16/MODBUS update by one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ 16'hA001;
      else c = c >> 1;
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// File: rtl/bsfr_ctrl.sv
// Controller state machine of the bus slave frame responder.
`default_nettype none
`include "bus_slave_frame_responder_unit_defines.svh"
module bsfr_ctrl import bsfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output bsfr_cmd_t cmd,
  input  bsfr_sts_t sts
);
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_REPLY  = 6'b001000,
    S_CRCLO  = 6'b010000,
    S_CRCHI  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (sts.frame_end) state_nxt = S_SCAN;
      S_SCAN:   if (sts.scan_done) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = sts.is_reply ? S_REPLY : S_IDLE;
      S_REPLY:  if (sts.reply_last) state_nxt = S_CRCLO;
      S_CRCLO:  state_nxt = S_CRCHI;
      S_CRCHI:  state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Commands
  assign busy = (state_r != S_IDLE);
  assign cmd.accept = start && (state_r == S_IDLE);
  assign cmd.scan_go = (state_r == S_SCAN);
  assign cmd.decide = (state_r == S_DECIDE);
  assign cmd.reply_go = (state_r == S_REPLY);
  assign cmd.crc_lo = (state_r == S_CRCLO);
  assign cmd.crc_hi = (state_r == S_CRCHI);

  `BSFR_ASSERT_NEXT(a_scan_to_decide, (state_r == S_SCAN) && sts.scan_done, state_r == S_DECIDE, "scan end lost")
  `BSFR_ASSERT_NEXT(a_crchi_to_idle, state_r == S_CRCHI, state_r == S_IDLE, "reply did not end")
  `BSFR_ASSERT_NEXT(a_status_to_idle, (state_r == S_DECIDE) && !sts.is_reply, state_r == S_IDLE, "status frame did not end")
endmodule
`default_nettype wire

// File: rtl/bsfr_dp.sv
// Datapath of the bus slave frame responder: frame store, CRC and reply.
`default_nettype none
module bsfr_dp import bsfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  bsfr_cmd_t  cmd,
  output bsfr_sts_t  sts,
  input  logic       in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic       out_strobe,
  output logic [2:0] out_status,
  output logic [7:0] out_tx_byte,
  output logic       out_last
);
  logic [7:0] mem [FRAME_BYTES];
  logic [LEN_W-1:0] len_r, rd_cnt_r, pi_r;
  logic [15:0] idle_r, gap_r, crc_r, rcrc_r;
  logic [7:0] own_r, rd_data_r, rxlo_r, rxhi_r;
  logic [7:0] hdr_r [13];
  logic pv_r, rtype_r;
  logic [4:0] rp_idx_r;
  logic out_valid_r, out_last_r;
  logic [2:0] out_status_r;
  logic [7:0] out_tx_r;

  logic is_byte, is_tick, full;
  logic [8:0] hdrlen, need, len9, pi9;
  logic [7:0] bc, msg;
  logic crc_good, w_bcast, w_scan, w_cmd, reply_sel, reply_typ;
  logic [2:0] dec_status;

  assign cfg_ready = 1'b1;
  assign is_byte = cmd.accept && !in_kind;
  assign is_tick = cmd.accept && in_kind;
  assign full = (len_r >= LEN_W'(FRAME_BYTES));

  // Frame header fields
  assign hdrlen = (hdr_r[1] == FN_WRITE) ? HDR16 : HDR23;
  assign bc = (hdr_r[1] == FN_WRITE) ? hdr_r[6] : hdr_r[10];
  assign need = hdrlen + {1'b0, bc};
  assign len9 = 9'(len_r);
  assign pi9 = 9'(pi_r);

  assign sts.frame_end = is_tick && (len_r != '0) && (idle_r >= gap_r);
  assign sts.scan_done = cmd.scan_go && (rd_cnt_r >= len_r) && !pv_r;

  // Classify the finished frame
  assign crc_good = (len9 >= need + 9'd2) && (crc_r == {rxhi_r, rxlo_r});
  assign w_bcast = (hdr_r[0] == 8'h00) && ({hdr_r[2], hdr_r[3]} == 16'h9d31) &&
                   ({hdr_r[4], hdr_r[5]} == 16'h0009) && (bc == 8'd18);
  assign w_scan = ({hdr_r[2], hdr_r[3]} == 16'h9cb9) && ({hdr_r[4], hdr_r[5]} == 16'h0005) &&
                  ({hdr_r[6], hdr_r[7]} == 16'h9c41) && ({hdr_r[8], hdr_r[9]} == 16'h0003) &&
                  (bc == 8'd6);
  assign w_cmd = ({hdr_r[2], hdr_r[3]} == 16'h9cb9) && ({hdr_r[4], hdr_r[5]} == 16'h0008) &&
                 ({hdr_r[6], hdr_r[7]} == 16'h9c41) && ({hdr_r[8], hdr_r[9]} == 16'h0002) &&
                 (bc == 8'd4);

  always_comb begin
    dec_status = ST_UNSUPP;
    reply_sel = 1'b0;
    reply_typ = 1'b0;
    if (len9 < 9'd2) dec_status = ST_BAD_FN;
    else if (hdr_r[1] == FN_WRITE) begin
      if (len9 < HDR16 || !crc_good) dec_status = ST_BAD_CRC;
      else if (w_bcast) dec_status = ST_BCAST_OK;
      else dec_status = ST_UNSUPP;
    end else if (hdr_r[1] != FN_RW) dec_status = ST_BAD_FN;
    else if (hdr_r[0] != own_r) dec_status = ST_NOT_ADDR;
    else if (len9 < HDR23 || !crc_good) dec_status = ST_BAD_CRC;
    else if (w_scan) begin
      reply_sel = 1'b1;
      reply_typ = 1'b0;
    end else if (w_cmd) begin
      reply_sel = 1'b1;
      reply_typ = 1'b1;
    end else dec_status = ST_UNSUPP;
  end
  assign sts.is_reply = reply_sel;
  assign sts.reply_last = (rp_idx_r == (rtype_r ? 5'd18 : 5'd12));

  // Reply byte for the current index
  always_comb begin
    msg = 8'h00;
    case (rp_idx_r)
      5'd0: msg = hdr_r[0];
      5'd1: msg = FN_RW;
      5'd2: msg = rtype_r ? 8'd16 : 8'd10;
      5'd3: msg = hdr_r[11];
      5'd5: msg = hdr_r[12];
      5'd6: msg = rtype_r ? 8'h01 : 8'h05;
      5'd7: msg = rtype_r ? 8'h00 : 8'h04;
      5'd8: msg = rtype_r ? 8'h00 : 8'h30;
      5'd9: msg = rtype_r ? 8'h00 : 8'h10;
      5'd10: msg = rtype_r ? 8'h00 : 8'hff;
      5'd11: msg = rtype_r ? 8'h00 : 8'ha8;
      5'd12: msg = rtype_r ? 8'h00 : 8'h45;
      default: msg = 8'h00;
    endcase
  end

  // Frame store: write on bytes, registered read during the scan
  always_ff @(posedge clk) begin
    if (is_byte && !full) mem[len_r[ADDR_W-1:0]] <= in_rx_byte;
    if (cmd.scan_go && rd_cnt_r < len_r) rd_data_r <= mem[rd_cnt_r[ADDR_W-1:0]];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= 8'd2;
      gap_r <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_ADDR: own_r <= cfg_data[7:0];
        CFG_GAP: gap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame length and idle count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      idle_r <= '0;
    end else if (is_byte) begin
      len_r <= full ? '0 : len_r + LEN_W'(1);
      idle_r <= '0;
    end else if (is_tick && len_r != '0 && idle_r < gap_r) begin
      idle_r <= idle_r + 16'd1;
    end else if (cmd.decide) begin
      len_r <= '0;
      idle_r <= '0;
    end
  end

  // Scan: walk the store, capture header and CRC bytes, check sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      rd_cnt_r <= '0;
    end else if (sts.frame_end) begin
      pv_r <= 1'b0;
      rd_cnt_r <= '0;
    end else if (cmd.scan_go) begin
      pv_r <= (rd_cnt_r < len_r);
      if (rd_cnt_r < len_r) rd_cnt_r <= rd_cnt_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_go && rd_cnt_r < len_r) pi_r <= rd_cnt_r;
    if (sts.frame_end) crc_r <= 16'hFFFF;
    else if (cmd.scan_go && pv_r) begin
      for (int k = 0; k < 13; k++) begin
        if (pi9 == 9'(k)) hdr_r[k] <= rd_data_r;
      end
      if (pi9 < hdrlen || pi9 < need) crc_r <= crc_byte(crc_r, rd_data_r);
      if (pi9 >= hdrlen && pi9 == need) rxlo_r <= rd_data_r;
      if (pi9 >= hdrlen && pi9 == need + 9'd1) rxhi_r <= rd_data_r;
    end
  end

  // Reply sequencing
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      rtype_r <= reply_typ;
      rp_idx_r <= '0;
      rcrc_r <= 16'hFFFF;
    end else if (cmd.reply_go) begin
      rp_idx_r <= rp_idx_r + 5'd1;
      rcrc_r <= crc_byte(rcrc_r, msg);
    end
  end

  // Result register: one cycle strobe per result
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= (is_byte && full) || (cmd.decide && !reply_sel) ||
                        cmd.reply_go || cmd.crc_lo || cmd.crc_hi;
    if (is_byte && full) begin
      out_status_r <= ST_OVERFLOW;
      out_tx_r <= 8'h00;
      out_last_r <= 1'b1;
    end else if (cmd.decide) begin
      out_status_r <= dec_status;
      out_tx_r <= 8'h00;
      out_last_r <= 1'b1;
    end else if (cmd.reply_go) begin
      out_status_r <= ST_BYTE;
      out_tx_r <= msg;
      out_last_r <= 1'b0;
    end else if (cmd.crc_lo) begin
      out_status_r <= ST_BYTE;
      out_tx_r <= rcrc_r[7:0];
      out_last_r <= 1'b0;
    end else if (cmd.crc_hi) begin
      out_status_r <= ST_BYTE;
      out_tx_r <= rcrc_r[15:8];
      out_last_r <= 1'b1;
    end else begin
      out_status_r <= ST_BYTE;
      out_tx_r <= 8'h00;
      out_last_r <= 1'b0;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_status = out_status_r;
  assign out_tx_byte = out_tx_r;
  assign out_last = out_last_r;
endmodule
`default_nettype wire

// File: rtl/bus_slave_frame_responder_unit.sv
// Top level of the bus slave frame responder.
//  channel | handshake                 | payload
//  input   | start high, busy low      | in_kind, in_rx_byte
//  result  | out_strobe, one cycle     | out_status, out_tx_byte, out_last
//  config  | cfg_valid and cfg_ready   | cfg_index, cfg_data
// A byte or a tick before the gap is taken while busy stays low.
// A frame-end tick walks the frame store one byte a cycle through the single
// read port, then a decode step, then up to 21 reply bytes one a cycle.
// Results are registered and appear in the cycle after the step that makes them; the receiver cannot stall.
// rst_n is synchronous, active low; the frame store has no reset.
`default_nettype none
module bus_slave_frame_responder_unit import bsfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [7:0]  out_tx_byte,
  output logic        out_last
);
  bsfr_cmd_t cmd;
  bsfr_sts_t sts;

  bsfr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  bsfr_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_kind), .in_rx_byte(in_rx_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_status(out_status), .out_tx_byte(out_tx_byte),
    .out_last(out_last)
  );
endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the bus slave frame responder: directed table, then random frames.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import bsfr_pkg::*;

  typedef struct {
    logic [2:0] status;
    logic [7:0] tx_byte;
    logic       last;
  } rsp_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum {FR_BCAST, FR_SCAN, FR_CMD, FR_JUNK, FR_OVF} frame_kind_t;

  typedef struct {
    row_kind_t   row;
    logic        kind;
    logic [7:0]  data;
    logic [15:0] gap;
    int          n_rsp;   // -1 when only the predictor decides
    logic [2:0]  status;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_kind = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic [0:0]  cfg_index = CFG_OWN_ADDR;
  logic [15:0] cfg_data = 16'h0000;
  logic        busy, cfg_ready, out_strobe, out_last;
  logic [2:0]  out_status;
  logic [7:0]  out_tx_byte;

  bus_slave_frame_responder_unit i_dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_rx_byte,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_strobe, .out_status, .out_tx_byte, .out_last
  );

  // Predictor state
  logic [7:0]  frame_mem [FRAME_BYTES];
  int          frame_len = 0;
  int          idle_ticks = 0;
  logic [7:0]  own_addr = 8'd2;
  logic [15:0] gap_ticks = 16'd1000;

  rsp_t        expected_rsp_q[$];
  dir_row_t    dir_table[$];
  int          errors = 0;
  int          items = 0;
  int          last_n_rsp;
  logic [2:0]  last_status;
  int          stall_cycles = 0;
  bit          no_gaps = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, exp, $time);
    errors++;
  endtask

  function automatic logic [15:0] crc16_of(input logic [7:0] bytes[$]);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (bytes[i]) begin
      c ^= {8'h00, bytes[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] word_at(input int i);
    return {frame_mem[i], frame_mem[i + 1]};
  endfunction

  function automatic bit stored_crc_ok(input int n);
    logic [7:0] q[$];
    for (int i = 0; i < n; i++) q.push_back(frame_mem[i]);
    return crc16_of(q) == {frame_mem[n + 1], frame_mem[n]};
  endfunction

  function automatic void push_status(input logic [2:0] st);
    rsp_t r;
    r.status = st;
    r.tx_byte = 8'h00;
    r.last = 1'b1;
    expected_rsp_q.push_back(r);
    last_n_rsp++;
    last_status = st;
  endfunction

  // Append the CRC, then queue every byte of the reply
  function automatic void push_reply(input logic [7:0] msg[$]);
    logic [15:0] c;
    rsp_t r;
    c = crc16_of(msg);
    msg.push_back(c[7:0]);
    msg.push_back(c[15:8]);
    foreach (msg[i]) begin
      r.status = ST_BYTE;
      r.tx_byte = msg[i];
      r.last = (i == msg.size() - 1);
      expected_rsp_q.push_back(r);
      last_n_rsp++;
    end
    last_status = ST_BYTE;
  endfunction

  function automatic void decode_frame();
    int bc;
    logic [7:0] msg[$];
    if (frame_len < 2) begin
      push_status(ST_BAD_FN);
    end else if (frame_mem[1] == FN_WRITE) begin
      if (frame_len < int'(HDR16)) begin
        push_status(ST_BAD_CRC);
      end else begin
        bc = frame_mem[6];
        if (frame_len < int'(HDR16) + bc + 2 || !stored_crc_ok(int'(HDR16) + bc))
          push_status(ST_BAD_CRC);
        else if (frame_mem[0] == 8'h00 && word_at(2) == 16'h9d31 && word_at(4) == 16'd9
                 && bc == 18)
          push_status(ST_BCAST_OK);
        else
          push_status(ST_UNSUPP);
      end
    end else if (frame_mem[1] != FN_RW) begin
      push_status(ST_BAD_FN);
    end else if (frame_mem[0] != own_addr) begin
      push_status(ST_NOT_ADDR);
    end else if (frame_len < int'(HDR23)) begin
      push_status(ST_BAD_CRC);
    end else begin
      bc = frame_mem[10];
      if (frame_len < int'(HDR23) + bc + 2 || !stored_crc_ok(int'(HDR23) + bc)) begin
        push_status(ST_BAD_CRC);
      end else if (word_at(2) == 16'h9cb9 && word_at(4) == 16'd5 && word_at(6) == 16'h9c41
                   && word_at(8) == 16'd3 && bc == 6) begin
        // bus scan answer
        msg = '{frame_mem[0], FN_RW, 8'd10, frame_mem[11], 8'h00, frame_mem[12],
                8'h05, 8'h04, 8'h30, 8'h10, 8'hff, 8'ha8, 8'h45};
        push_reply(msg);
      end else if (word_at(2) == 16'h9cb9 && word_at(4) == 16'd8 && word_at(6) == 16'h9c41
                   && word_at(8) == 16'd2 && bc == 4) begin
        // command answer, zero padded
        msg = '{frame_mem[0], FN_RW, 8'd16, frame_mem[11], 8'h00, frame_mem[12], 8'h01};
        while (msg.size() < 19) msg.push_back(8'h00);
        push_reply(msg);
      end else begin
        push_status(ST_UNSUPP);
      end
    end
  endfunction

  function automatic void predict_item(input logic kind, input logic [7:0] data);
    last_n_rsp = 0;
    if (!kind) begin
      if (frame_len >= FRAME_BYTES) begin
        frame_len = 0;
        idle_ticks = 0;
        push_status(ST_OVERFLOW);
      end else begin
        frame_mem[frame_len] = data;
        frame_len++;
        idle_ticks = 0;
      end
    end else if (frame_len != 0) begin
      if (idle_ticks < gap_ticks) begin
        idle_ticks++;
      end else begin
        decode_frame();
        frame_len = 0;
        idle_ticks = 0;
      end
    end
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send_item(input logic kind, input logic [7:0] data);
    int wait_cycles;
    wait_cycles = no_gaps ? 0 : $urandom_range(0, 4);
    if (wait_cycles > 0) begin
      start <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_rx_byte <= data;
    do @(negedge clk); while (busy);
    @(posedge clk);
    predict_item(kind, data);
    items++;
  endtask

  // Drain all results, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] addr, input logic [15:0] gap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OWN_ADDR;
    cfg_data <= {8'h00, addr};
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    own_addr = addr;
    cfg_index <= CFG_GAP;
    cfg_data <= gap;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    gap_ticks = gap;
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(input row_kind_t row, input logic kind, input logic [7:0] data,
                                  input logic [15:0] gap, input int n_rsp,
                                  input logic [2:0] st);
    dir_row_t r;
    r.row = row;
    r.kind = kind;
    r.data = data;
    r.gap = gap;
    r.n_rsp = n_rsp;
    r.status = st;
    dir_table.push_back(r);
  endfunction

  // Build one frame with random content, then send it and the ticks that end it
  task automatic send_frame(input frame_kind_t fk);
    logic [7:0] fr[$];
    logic [15:0] c;
    int pos;
    int n_ticks;
    fr.delete();
    case (fk)
      FR_BCAST: begin
        fr = '{8'h00, FN_WRITE, 8'h9d, 8'h31, 8'h00, 8'h09, 8'd18};
        repeat (18) fr.push_back($urandom_range(0, 255));
      end
      FR_SCAN: begin
        fr = '{own_addr, FN_RW, 8'h9c, 8'hb9, 8'h00, 8'h05, 8'h9c, 8'h41, 8'h00, 8'h03, 8'd6};
        repeat (6) fr.push_back($urandom_range(0, 255));
      end
      FR_CMD: begin
        fr = '{own_addr, FN_RW, 8'h9c, 8'hb9, 8'h00, 8'h08, 8'h9c, 8'h41, 8'h00, 8'h02, 8'd4};
        repeat (4) fr.push_back($urandom_range(0, 255));
      end
      FR_JUNK: begin
        repeat ($urandom_range(1, 20)) fr.push_back($urandom_range(0, 255));
        if ($urandom_range(0, 1)) fr[0] = own_addr;
        if (fr.size() > 1 && $urandom_range(0, 1)) fr[1] = $urandom_range(0, 1) ? FN_RW : FN_WRITE;
      end
      default: begin
        repeat (FRAME_BYTES + 1) fr.push_back($urandom_range(0, 255));
      end
    endcase
    if (fk != FR_OVF && fk != FR_JUNK) begin
      // wrong address or altered header, then a valid CRC
      if ($urandom_range(0, 4) == 0) fr[0] = $urandom_range(0, 255);
      if ($urandom_range(0, 5) == 0) fr[$urandom_range(2, 9)] ^= 8'h01;
      c = crc16_of(fr);
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      // corrupt a bit or cut the frame short
      if ($urandom_range(0, 5) == 0) begin
        pos = $urandom_range(0, fr.size() - 1);
        fr[pos] ^= 8'h01 << $urandom_range(0, 7);
      end else if ($urandom_range(0, 7) == 0) begin
        fr = fr[0:$urandom_range(2, fr.size() - 2)];
      end
    end
    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (fr[i]) send_item(1'b0, fr[i]);
    n_ticks = gap_ticks + 1 + $urandom_range(0, 2);
    repeat (n_ticks) send_item(1'b1, $urandom_range(0, 255));
  endtask

  // Compare each result with the oldest expectation
  always @(negedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, -1);
      end else begin
        if (out_status !== expected_rsp_q[0].status)
          report_mismatch("status", out_status, expected_rsp_q[0].status);
        if (out_tx_byte !== expected_rsp_q[0].tx_byte)
          report_mismatch("tx_byte", out_tx_byte, expected_rsp_q[0].tx_byte);
        if (out_last !== expected_rsp_q[0].last)
          report_mismatch("last", out_last, expected_rsp_q[0].last);
        void'(expected_rsp_q.pop_front());
      end
    end
  end

  // Stop the run when no transaction moves for too long
  always @(negedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 3000) begin
      $display("bus_slave_frame_responder_unit verification failed");
      $finish;
    end
  end

  initial begin
    int phase;
    logic [7:0] addr;
    frame_kind_t fk;
    // Long gap holds the frame; then zero gap ends it on the next tick
    add_row(ROW_CFG, 1'b0, 8'd2, 16'hFFFF, -1, ST_BYTE);
    add_row(ROW_ITEM, 1'b0, 8'h00, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b0, 8'hFF, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b1, 8'hFF, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b1, 8'h00, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b1, 8'hA5, 16'h0, 0, ST_BYTE);
    add_row(ROW_CFG, 1'b0, 8'd2, 16'h0000, -1, ST_BYTE);
    add_row(ROW_ITEM, 1'b1, 8'h00, 16'h0, 1, ST_BAD_FN);
    // tick with empty store
    add_row(ROW_ITEM, 1'b1, 8'h5A, 16'h0, 0, ST_BYTE);
    // single byte frame
    add_row(ROW_ITEM, 1'b0, 8'h05, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b1, 8'h00, 16'h0, 1, ST_BAD_FN);
    // broadcast header cut short
    add_row(ROW_ITEM, 1'b0, 8'h07, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b0, FN_WRITE, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b1, 8'h00, 16'h0, 1, ST_BAD_CRC);
    // request to another address
    add_row(ROW_ITEM, 1'b0, 8'hFF, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b0, FN_RW, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b1, 8'h00, 16'h0, 1, ST_NOT_ADDR);
    // own address, header cut short
    add_row(ROW_ITEM, 1'b0, 8'h02, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b0, FN_RW, 16'h0, 0, ST_BYTE);
    add_row(ROW_ITEM, 1'b1, 8'h00, 16'h0, 1, ST_BAD_CRC);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].row == ROW_CFG) begin
        wait_idle();
        write_regs(dir_table[i].data, dir_table[i].gap);
      end else begin
        send_item(dir_table[i].kind, dir_table[i].data);
        if (last_n_rsp != dir_table[i].n_rsp)
          report_mismatch("directed row result count", last_n_rsp, dir_table[i].n_rsp);
        else if (last_n_rsp == 1 && last_status != dir_table[i].status)
          report_mismatch("directed row status", last_status, dir_table[i].status);
      end
    end

    // Random phases, each with its own register setting
    phase = 0;
    while (items < 180) begin
      case (phase)
        0: addr = 8'h00;
        1: addr = 8'hFF;
        2: addr = 8'h02;
        default: addr = $urandom_range(0, 255);
      endcase
      wait_idle();
      write_regs(addr, $urandom_range(0, 3));
      for (int j = 0; j < 3; j++) begin
        if (phase == 1 && j == 0) fk = FR_OVF;
        else begin
          case ($urandom_range(0, 8))
            0, 1, 2: fk = FR_BCAST;
            3, 4:    fk = FR_SCAN;
            5, 6:    fk = FR_CMD;
            default: fk = FR_JUNK;
          endcase
        end
        send_frame(fk);
      end
      phase++;
    end

    wait_idle();
    if (errors == 0)
      $display("bus_slave_frame_responder_unit verification clean");
    else
      $display("bus_slave_frame_responder_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire
